>>> rtl/core/bal3d_pkg.sv
// types, constants and microprogram of the balanced three-factor split
package bal3d_pkg;

  localparam int NODE_W    = 11;
  localparam int LARGE_W   = 11;
  localparam int MIDDLE_W  = 6;
  localparam int SMALL_W   = 4;
  localparam int A_W       = 4;
  localparam int B_W       = 6;
  localparam int AB_W      = 10;
  localparam int T_W       = 15;
  localparam int SQ_W      = 22;
  localparam int DIV_CNT_W = 4;
  localparam int PC_W      = 4;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NODE_W - 1);

  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_A_LOOP = 4'd2;
  localparam logic [PC_W-1:0] PC_B_LOOP = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV    = 4'd8;
  localparam logic [PC_W-1:0] PC_INC_B  = 4'd12;
  localparam logic [PC_W-1:0] PC_INC_A  = 4'd13;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_SQ_A,
    OP_CUBE,
    OP_SET_B,
    OP_AB,
    OP_ABB,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQ_C,
    OP_SQ_AB,
    OP_UPDATE,
    OP_INC_B,
    OP_INC_A,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_REQ,
    COND_BAD_N,
    COND_T_GT_N,
    COND_DIV_MORE,
    COND_REM_NZ,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_req;
    logic bad_n;
    logic t_gt_n;
    logic div_more;
    logic rem_nz;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = '{OP_IDLE,     COND_NO_REQ,   PC_IDLE};
      4'd1:    w = '{OP_NOP,      COND_BAD_N,    PC_EMIT};
      4'd2:    w = '{OP_SQ_A,     COND_NEVER,    PC_IDLE};
      4'd3:    w = '{OP_CUBE,     COND_NEVER,    PC_IDLE};
      4'd4:    w = '{OP_SET_B,    COND_T_GT_N,   PC_EMIT};
      4'd5:    w = '{OP_AB,       COND_NEVER,    PC_IDLE};
      4'd6:    w = '{OP_ABB,      COND_NEVER,    PC_IDLE};
      4'd7:    w = '{OP_DIV_INIT, COND_T_GT_N,   PC_INC_A};
      4'd8:    w = '{OP_DIV_STEP, COND_DIV_MORE, PC_DIV};
      4'd9:    w = '{OP_SQ_C,     COND_REM_NZ,   PC_INC_B};
      4'd10:   w = '{OP_SQ_AB,    COND_NEVER,    PC_IDLE};
      4'd11:   w = '{OP_UPDATE,   COND_NEVER,    PC_IDLE};
      4'd12:   w = '{OP_INC_B,    COND_ALWAYS,   PC_B_LOOP};
      4'd13:   w = '{OP_INC_A,    COND_ALWAYS,   PC_A_LOOP};
      4'd15:   w = '{OP_EMIT,     COND_OUT_BUSY, PC_EMIT};
      default: w = '{OP_NOP,      COND_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/bal3d_if.sv
// request and result channel interfaces
interface bal3d_req_if;
  logic                          valid;
  logic                          ready;
  logic [bal3d_pkg::NODE_W-1:0]  node_count;

  modport source (output valid, output node_count, input ready);
  modport sink (input valid, input node_count, output ready);
endinterface

interface bal3d_res_if;
  logic                           valid;
  logic                           ready;
  logic [bal3d_pkg::LARGE_W-1:0]  grid_large;
  logic [bal3d_pkg::MIDDLE_W-1:0] grid_middle;
  logic [bal3d_pkg::SMALL_W-1:0]  grid_small;
  logic                           valid_res;

  modport source (output valid, output grid_large, output grid_middle, output grid_small,
                  output valid_res, input ready);
  modport sink (input valid, input grid_large, input grid_middle, input grid_small,
                input valid_res, output ready);
endinterface

>>> rtl/core/bal3d_seq.sv
// microprogram sequencer: step counter, control store and conditional jumps
module bal3d_seq (
  input  logic              clk,
  input  logic              rst,
  input  bal3d_pkg::stat_t  stat,
  output bal3d_pkg::ctrl_t  cw
);
  import bal3d_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign cw = ucode(pc);

  always_comb begin
    case (cw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_NEVER:    take = 1'b0;
      COND_NO_REQ:   take = stat.no_req;
      COND_BAD_N:    take = stat.bad_n;
      COND_T_GT_N:   take = stat.t_gt_n;
      COND_DIV_MORE: take = stat.div_more;
      COND_REM_NZ:   take = stat.rem_nz;
      COND_OUT_BUSY: take = stat.out_busy;
      default:       take = 1'b0;
    endcase
  end

  assign pc_next = take ? cw.target : pc + PC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> rtl/core/bal3d_dp.sv
// search datapath: factor registers, multiplier, shift-subtract divider, result register
module bal3d_dp #(
  parameter int MAX_NODES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  bal3d_pkg::ctrl_t   cw,
  output bal3d_pkg::stat_t   stat,
  bal3d_req_if.sink          node_in,
  bal3d_res_if.source        grid_out
);
  import bal3d_pkg::*;

  logic [NODE_W-1:0]    n;
  logic [A_W-1:0]       a;
  logic [B_W-1:0]       b;
  logic [AB_W-1:0]      ab;
  logic [T_W-1:0]       t;
  logic [NODE_W-1:0]    quo;
  logic [AB_W-1:0]      rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SQ_W-1:0]      sq;
  logic [SQ_W-1:0]      best;
  logic [A_W-1:0]       bi;
  logic [B_W-1:0]       bj;
  logic [NODE_W-1:0]    bk;

  logic                 out_valid;
  logic [LARGE_W-1:0]   out_large;
  logic [MIDDLE_W-1:0]  out_middle;
  logic [SMALL_W-1:0]   out_small;
  logic                 out_res;

  logic [NODE_W-1:0]    trial;
  logic                 trial_ge;
  logic [2*A_W-1:0]     aa;
  logic [2*B_W-1:0]     bb;

  assign trial    = {rem, quo[NODE_W-1]};
  assign trial_ge = trial >= NODE_W'(ab);
  assign aa       = a * a;
  assign bb       = b * b;

  assign stat.no_req   = ~node_in.valid;
  assign stat.bad_n    = (n == '0) || (32'(n) > MAX_NODES);
  assign stat.t_gt_n   = t > T_W'(n);
  assign stat.div_more = div_cnt != DIV_LAST;
  assign stat.rem_nz   = rem != '0;
  assign stat.out_busy = out_valid & ~grid_out.ready;

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_IDLE: begin
        if (node_in.valid) begin
          n    <= node_in.node_count;
          a    <= A_W'(1);
          best <= '1;
          bi   <= '0;
          bj   <= '0;
          bk   <= '0;
        end
      end
      OP_SQ_A:     t <= T_W'(aa);
      OP_CUBE:     t <= T_W'(t * T_W'(a));
      OP_SET_B:    b <= B_W'(a);
      OP_AB:       ab <= AB_W'(a) * AB_W'(b);
      OP_ABB:      t <= T_W'(ab) * T_W'(b);
      OP_DIV_INIT: begin
        quo     <= n;
        rem     <= '0;
        div_cnt <= '0;
      end
      OP_DIV_STEP: begin
        quo     <= {quo[NODE_W-2:0], trial_ge};
        rem     <= trial_ge ? AB_W'(trial - NODE_W'(ab)) : AB_W'(trial);
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      OP_SQ_C:     sq <= SQ_W'(quo) * SQ_W'(quo);
      OP_SQ_AB:    sq <= sq + SQ_W'(aa) + SQ_W'(bb);
      OP_UPDATE: begin
        if (sq < best) begin
          best <= sq;
          bi   <= a;
          bj   <= b;
          bk   <= quo;
        end
      end
      OP_INC_B:    b <= b + B_W'(1);
      OP_INC_A:    a <= a + A_W'(1);
      OP_EMIT: begin
        if (!stat.out_busy) begin
          out_large  <= LARGE_W'(bk);
          out_middle <= MIDDLE_W'(bj);
          out_small  <= SMALL_W'(bi);
          out_res    <= ~stat.bad_n;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT && !stat.out_busy) begin
      out_valid <= 1'b1;
    end else if (grid_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign grid_out.valid       = out_valid;
  assign grid_out.grid_large  = out_large;
  assign grid_out.grid_middle = out_middle;
  assign grid_out.grid_small  = out_small;
  assign grid_out.valid_res   = out_res;

endmodule

>>> rtl/core/balanced_3d_factorization_top.sv
// top level of the balanced three-factor split of a node count
//
// node_in carries a request with node_count n; grid_out returns one result per
// request: the split n = i*j*k with i <= j <= k of least i*i + j*j + k*k, given
// as grid_large = k, grid_middle = j, grid_small = i and valid_res = 1. for n = 0
// or n above MAX_NODES all factors are zero and valid_res is 0.
// both channels use valid/ready; a request is taken when both are high.
// a microcoded sequencer steps a small datapath through the search. node_in is
// ready only while the sequencer sits at its idle step, so one request is
// worked at a time. each candidate pair (i, j) passes through the shift-subtract
// divider that forms n / (i*j); a rejected count skips the search and goes
// straight to the final step.
// the result sits in an output register, so the next request is taken while
// it waits; if grid_out stays stalled, the following result holds at the
// final step until the register frees.
// rst is synchronous; it returns the sequencer to idle and drops grid_out.valid.
module balanced_3d_factorization_top #(
  parameter int MAX_NODES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  bal3d_req_if.sink     node_in,
  bal3d_res_if.source   grid_out
);
  import bal3d_pkg::*;

  ctrl_t cw;
  stat_t stat;

  assign node_in.ready = (cw.op == OP_IDLE) && !rst;

  bal3d_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  bal3d_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cw       (cw),
    .stat     (stat),
    .node_in  (node_in),
    .grid_out (grid_out)
  );

  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(grid_out.valid) |-> $past(cw.op == OP_EMIT))
    else $error("result appeared outside the emit step");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (node_in.valid && node_in.ready) |=> (cw.op != OP_IDLE))
    else $error("sequencer stayed idle after taking a request");

  a_nonzero_split: assert property (@(posedge clk) disable iff (rst)
    (grid_out.valid && grid_out.valid_res) |->
      (grid_out.grid_large != '0 && grid_out.grid_small != '0))
    else $error("valid split with a zero factor");

endmodule
